@@ rtl/core/keyed_result_cache_fifo_unit_macros.svh @@
// assertion helpers used by the checker file
`ifndef KEYED_RESULT_CACHE_FIFO_UNIT_MACROS_SVH
`define KEYED_RESULT_CACHE_FIFO_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define KRC_ASSERT_IMP(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("keyed result cache check failed");

// next-cycle implication, disabled during reset
`define KRC_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("keyed result cache check failed");

`endif

@@ rtl/core/krc_pkg.sv @@
`default_nettype none

package krc_pkg;

   // storage geometry
   localparam int SLOTS       = 16;
   localparam int SLOT_BITS   = $clog2(SLOTS);
   localparam int FILL_BITS   = $clog2(SLOTS + 1);
   localparam int KEY_BITS    = 64;
   localparam int DATA_BITS   = 64;
   localparam int RESULT_BITS = 64;
   localparam int STAMP_BITS  = 32;
   localparam int COUNT_BITS  = 32;
   localparam int CAP_BITS    = 5;

   // register port
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_IDX_BITS  = CSR_ADDR_BITS - 2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_ENTRIES_IN_USE = '0;
   localparam logic [CAP_BITS-1:0]     CAP_RESET = CAP_BITS'(SLOTS);

   typedef enum logic [1:0] {
      REQ_LOOKUP      = 2'd0,
      REQ_FILL        = 2'd1,
      REQ_INVALIDATE  = 2'd2,
      REQ_CLEAR_STATS = 2'd3
   } req_type_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SEARCH,
      ST_WRITE,
      ST_FINISH
   } state_type;

   // flags from the shared comparator
   typedef struct packed {
      logic eq;
      logic lt;
   } cmp_result_type;

endpackage

`default_nettype wire

@@ rtl/core/krc_cmp.sv @@
`default_nettype none

module krc_cmp (
   input  wire logic [krc_pkg::KEY_BITS-1:0] a,
   input  wire logic [krc_pkg::KEY_BITS-1:0] b,
   output krc_pkg::cmp_result_type           result
);
   import krc_pkg::*;

   logic [KEY_BITS:0] diff;

   // one subtractor gives both equality and unsigned less-than
   always_comb begin
      diff      = {1'b0, a} - {1'b0, b};
      result.lt = diff[KEY_BITS];
      result.eq = (diff[KEY_BITS-1:0] == '0);
   end

endmodule

`default_nettype wire

@@ rtl/core/keyed_result_cache_fifo_unit.sv @@
// channel   direction  handshake                 word
// req       in         req_valid / req_stall     req_type, req_key, req_fill_data
// rsp       out        rsp_valid / rsp_stall     hit, read_data, evicted, three totals
// csr       in/out     psel, penable, pwrite     paddr, pwdata, prdata, pready
//
// lookup: compares the filled slots in order from slot zero until the first hit or the last filled slot
// fill: writes a free slot, or when full first searches the filled slots for the oldest stamp and evicts it
// invalidate and clear-stats go straight to finish; one 64-bit comparator looks at one slot a cycle
// req_stall is high from acceptance until the result enters the output register
// a held result on rsp keeps the block in its finish state, so it also delays acceptance of the next word
// synchronous reset: empty cache, counters zero, stamp one, entries_in_use sixteen
`default_nettype none

module keyed_result_cache_fifo_unit (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // request words
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [1:0]                          req_type,
   input  wire logic [krc_pkg::KEY_BITS-1:0]        req_key,
   input  wire logic [krc_pkg::RESULT_BITS-1:0]     req_fill_data,
   // result words
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic                                     rsp_hit,
   output logic [krc_pkg::RESULT_BITS-1:0]          rsp_read_data,
   output logic                                     rsp_evicted,
   output logic [krc_pkg::COUNT_BITS-1:0]           rsp_hit_total,
   output logic [krc_pkg::COUNT_BITS-1:0]           rsp_miss_total,
   output logic [krc_pkg::COUNT_BITS-1:0]           rsp_eviction_total,
   // register port
   input  wire logic                                psel,
   input  wire logic                                penable,
   input  wire logic                                pwrite,
   input  wire logic [krc_pkg::CSR_ADDR_BITS-1:0]   paddr,
   input  wire logic [krc_pkg::CSR_DATA_BITS-1:0]   pwdata,
   output logic [krc_pkg::CSR_DATA_BITS-1:0]        prdata,
   output logic                                     pready
);
   import krc_pkg::*;

   // entry storage
   logic [KEY_BITS-1:0]   key_mem   [SLOTS];
   logic [DATA_BITS-1:0]  data_mem  [SLOTS];
   logic [STAMP_BITS-1:0] stamp_mem [SLOTS];
   logic [SLOTS-1:0]      valid_ff, valid_in;

   // control and item state
   state_type             state_ff, state_in;
   req_type_type          type_ff, type_in;
   logic [KEY_BITS-1:0]   key_ff, key_in;
   logic [DATA_BITS-1:0]  fdata_ff, fdata_in;
   logic [FILL_BITS-1:0]  idx_ff, idx_in;
   logic [SLOT_BITS-1:0]  best_ff, best_in;
   logic [STAMP_BITS-1:0] best_stamp_ff, best_stamp_in;
   logic [SLOT_BITS-1:0]  slot_ff, slot_in;
   logic                  evict_ff, evict_in;
   logic                  hit_ff, hit_in;
   logic [DATA_BITS-1:0]  rdata_ff, rdata_in;

   // cache-wide state
   logic [CAP_BITS-1:0]   eiu_ff, eiu_in;
   logic [FILL_BITS-1:0]  filled_ff, filled_in;
   logic [STAMP_BITS-1:0] next_stamp_ff, next_stamp_in;
   logic [COUNT_BITS-1:0] hit_cnt_ff, hit_cnt_in;
   logic [COUNT_BITS-1:0] miss_cnt_ff, miss_cnt_in;
   logic [COUNT_BITS-1:0] evict_cnt_ff, evict_cnt_in;

   // output register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_hit_ff;
   logic [DATA_BITS-1:0]   rsp_rdata_ff;
   logic                   rsp_evicted_ff;
   logic [COUNT_BITS-1:0]  rsp_hit_total_ff, rsp_miss_total_ff, rsp_evict_total_ff;

   // datapath helpers
   logic [FILL_BITS-1:0]  capacity;
   logic [SLOT_BITS-1:0]  rd_idx;
   logic [SLOT_BITS-1:0]  rd_addr;
   logic [KEY_BITS-1:0]   rd_key_ff;
   logic [DATA_BITS-1:0]  rd_data_ff;
   logic [STAMP_BITS-1:0] rd_stamp_ff;
   logic                  rd_valid;
   logic [KEY_BITS-1:0]   cmp_a, cmp_b;
   cmp_result_type        cmp;
   logic                  key_match;
   logic                  scan_last;
   logic                  search_done;
   logic                  out_free;
   logic                  finish_load;
   logic                  csr_wr;
   logic                  csr_hit;

   // effective capacity: zero acts as one, saturate at the slot count
   always_comb begin
      if (eiu_ff == '0) begin
         capacity = FILL_BITS'(1);
      end else if (32'(eiu_ff) > SLOTS) begin
         capacity = FILL_BITS'(SLOTS);
      end else begin
         capacity = FILL_BITS'(eiu_ff);
      end
   end

   // slot at the scan index; entry words come from the registered read
   assign rd_idx   = idx_ff[SLOT_BITS-1:0];
   assign rd_addr  = idx_in[SLOT_BITS-1:0];
   assign rd_valid = valid_ff[rd_idx];

   // shared comparator: keys while scanning, stamps while searching
   always_comb begin
      if (state_ff == ST_SEARCH) begin
         cmp_a = KEY_BITS'(rd_stamp_ff);
         cmp_b = KEY_BITS'(best_stamp_ff);
      end else begin
         cmp_a = rd_key_ff;
         cmp_b = key_ff;
      end
   end

   krc_cmp u_cmp (
      .a      (cmp_a),
      .b      (cmp_b),
      .result (cmp)
   );

   assign key_match   = cmp.eq && rd_valid;
   assign scan_last   = ((idx_ff + FILL_BITS'(1)) == filled_ff);
   assign search_done = (idx_ff >= filled_ff);
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign finish_load = (state_ff == ST_FINISH) && out_free;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (req_type_type'(req_type))
                  REQ_LOOKUP: state_in = (filled_ff == '0) ? ST_FINISH : ST_SCAN;
                  REQ_FILL:   state_in = (filled_ff < capacity) ? ST_WRITE : ST_SEARCH;
                  default:    state_in = ST_FINISH;
               endcase
            end
         end
         ST_SCAN: begin
            if (key_match || scan_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_SEARCH: begin
            if (search_done) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE:  state_in = ST_FINISH;
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   // datapath and cache state updates
   always_comb begin
      type_in       = type_ff;
      key_in        = key_ff;
      fdata_in      = fdata_ff;
      idx_in        = idx_ff;
      best_in       = best_ff;
      best_stamp_in = best_stamp_ff;
      slot_in       = slot_ff;
      evict_in      = evict_ff;
      hit_in        = hit_ff;
      rdata_in      = rdata_ff;
      valid_in      = valid_ff;
      filled_in     = filled_ff;
      next_stamp_in = next_stamp_ff;
      hit_cnt_in    = hit_cnt_ff;
      miss_cnt_in   = miss_cnt_ff;
      evict_cnt_in  = evict_cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               type_in       = req_type_type'(req_type);
               key_in        = req_key;
               fdata_in      = req_fill_data[DATA_BITS-1:0];
               idx_in        = '0;
               best_in       = '0;
               slot_in       = filled_ff[SLOT_BITS-1:0];
               evict_in      = 1'b0;
               hit_in        = 1'b0;
               rdata_in      = '0;
            end
         end
         ST_SCAN: begin
            if (key_match) begin
               hit_in   = 1'b1;
               rdata_in = rd_data_ff;
            end
            idx_in = idx_ff + FILL_BITS'(1);
         end
         ST_SEARCH: begin
            if (search_done) begin
               slot_in  = best_ff;
               evict_in = 1'b1;
            end else begin
               // the first slot seeds the oldest candidate
               if ((idx_ff == '0) || cmp.lt) begin
                  best_in       = rd_idx;
                  best_stamp_in = rd_stamp_ff;
               end
               idx_in = idx_ff + FILL_BITS'(1);
            end
         end
         ST_WRITE: begin
            valid_in[slot_ff] = 1'b1;
            next_stamp_in     = next_stamp_ff + STAMP_BITS'(1);
            if (!evict_ff) begin
               filled_in = filled_ff + FILL_BITS'(1);
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               case (type_ff)
                  REQ_LOOKUP: begin
                     if (hit_ff) begin
                        hit_cnt_in = hit_cnt_ff + COUNT_BITS'(1);
                     end else begin
                        miss_cnt_in = miss_cnt_ff + COUNT_BITS'(1);
                     end
                  end
                  REQ_FILL: begin
                     if (evict_ff) begin
                        evict_cnt_in = evict_cnt_ff + COUNT_BITS'(1);
                     end
                  end
                  REQ_INVALIDATE: begin
                     valid_in  = '0;
                     filled_in = '0;
                  end
                  default: begin
                     hit_cnt_in   = '0;
                     miss_cnt_in  = '0;
                     evict_cnt_in = '0;
                  end
               endcase
            end
         end
         default: begin
            idx_in = '0;
         end
      endcase
   end

   // output register valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (finish_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // register port
   assign csr_wr  = psel && penable && pwrite;
   assign csr_hit = (paddr[CSR_ADDR_BITS-1:2] == CSR_ENTRIES_IN_USE);
   assign eiu_in  = (csr_wr && csr_hit) ? pwdata[CAP_BITS-1:0] : eiu_ff;
   assign prdata  = csr_hit ? CSR_DATA_BITS'(eiu_ff) : '0;
   assign pready  = 1'b1;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         valid_ff      <= '0;
         filled_ff     <= '0;
         next_stamp_ff <= STAMP_BITS'(1);
         hit_cnt_ff    <= '0;
         miss_cnt_ff   <= '0;
         evict_cnt_ff  <= '0;
         eiu_ff        <= CAP_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         valid_ff      <= valid_in;
         filled_ff     <= filled_in;
         next_stamp_ff <= next_stamp_in;
         hit_cnt_ff    <= hit_cnt_in;
         miss_cnt_ff   <= miss_cnt_in;
         evict_cnt_ff  <= evict_cnt_in;
         eiu_ff        <= eiu_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // item payload registers
   always_ff @(posedge clock) begin
      type_ff       <= type_in;
      key_ff        <= key_in;
      fdata_ff      <= fdata_in;
      idx_ff        <= idx_in;
      best_ff       <= best_in;
      best_stamp_ff <= best_stamp_in;
      slot_ff       <= slot_in;
      evict_ff      <= evict_in;
      hit_ff        <= hit_in;
      rdata_ff      <= rdata_in;
   end

   // entry writes
   always_ff @(posedge clock) begin
      if (state_ff == ST_WRITE) begin
         key_mem[slot_ff]   <= key_ff;
         data_mem[slot_ff]  <= fdata_ff;
         stamp_mem[slot_ff] <= next_stamp_ff;
      end
   end

   // entry reads, addressed by the next scan index
   always_ff @(posedge clock) begin
      rd_key_ff   <= key_mem[rd_addr];
      rd_data_ff  <= data_mem[rd_addr];
      rd_stamp_ff <= stamp_mem[rd_addr];
   end

   // result payload
   always_ff @(posedge clock) begin
      if (finish_load) begin
         rsp_hit_ff         <= hit_ff;
         rsp_rdata_ff       <= rdata_ff;
         rsp_evicted_ff     <= evict_ff;
         rsp_hit_total_ff   <= hit_cnt_in;
         rsp_miss_total_ff  <= miss_cnt_in;
         rsp_evict_total_ff <= evict_cnt_in;
      end
   end

   assign req_stall          = (state_ff != ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_hit            = rsp_hit_ff;
   assign rsp_read_data      = RESULT_BITS'(rsp_rdata_ff);
   assign rsp_evicted        = rsp_evicted_ff;
   assign rsp_hit_total      = rsp_hit_total_ff;
   assign rsp_miss_total     = rsp_miss_total_ff;
   assign rsp_eviction_total = rsp_evict_total_ff;

endmodule

`default_nettype wire

@@ rtl/core/krc_checker.sv @@
`default_nettype none

`include "keyed_result_cache_fifo_unit_macros.svh"

module krc_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_valid,
   input wire logic                            req_stall,
   input wire logic                            rsp_valid,
   input wire logic                            rsp_stall,
   input wire logic                            rsp_hit,
   input wire logic [krc_pkg::RESULT_BITS-1:0] rsp_read_data,
   input wire logic                            rsp_evicted
);

   // a held result word stays offered
   `KRC_ASSERT_NEXT(a_rsp_held, clock, reset, rsp_valid && rsp_stall, rsp_valid)

   // the block is busy in the cycle after it takes a word
   `KRC_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)

   // no hit means no read data
   `KRC_ASSERT_IMP(a_miss_zero_data, clock, reset, rsp_valid && !rsp_hit, rsp_read_data == '0)

   // a lookup hit and a fill eviction never share one word
   `KRC_ASSERT_IMP(a_hit_or_evict, clock, reset, rsp_valid, !(rsp_hit && rsp_evicted))

endmodule

bind keyed_result_cache_fifo_unit krc_checker u_krc_checker (.*);

`default_nettype wire
